[rtl/bounded_stack_sort_reverse_core_defines.svh]
// shared assertion macros for the stack core
`ifndef BOUNDED_STACK_SORT_REVERSE_CORE_DEFINES_SVH
`define BOUNDED_STACK_SORT_REVERSE_CORE_DEFINES_SVH

// same-cycle implication
`define BSSR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BSSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/bssr_pkg.sv]
`timescale 1ns / 1ps

package bssr_pkg;

    localparam int WordW   = 32;
    localparam int ActW    = 3;
    localparam int StatW   = 2;
    localparam int CntOutW = 4;
    localparam int InTdataW  = 40;
    localparam int OutTdataW = 40;

    typedef enum logic [ActW-1:0] {
        ACT_PUSH    = 3'd0,
        ACT_POP     = 3'd1,
        ACT_PEEK    = 3'd2,
        ACT_CLEAR   = 3'd3,
        ACT_REVERSE = 3'd4,
        ACT_SORT    = 3'd5
    } t_action;

    typedef enum logic [StatW-1:0] {
        STAT_OK       = 2'd0,
        STAT_OVERFLOW = 2'd1,
        STAT_EMPTY    = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_PUSH,
        DP_POP,
        DP_PEEK,
        DP_CLEAR,
        DP_REV_INIT,
        DP_REV_RD_LO,
        DP_REV_RD_HI,
        DP_REV_WR_LO,
        DP_REV_WR_HI,
        DP_SORT_INIT,
        DP_SORT_RD_KEY,
        DP_SORT_LOAD_KEY,
        DP_SORT_RD_PREV,
        DP_SORT_SHIFT,
        DP_SORT_PLACE
    } t_dp_op;

    typedef struct packed {
        t_dp_op  op;
        logic    out_load;
        t_status out_status;
        logic    out_use_rd;
    } t_dp_cmd;

    typedef struct packed {
        logic empty;
        logic full;
        logic lo_lt_hi;
        logic i_lt_count;
        logic j_nz;
        logic key_gt;
    } t_dp_stat;

endpackage

[rtl/bssr_dpath.sv]
`timescale 1ns / 1ps
`include "bounded_stack_sort_reverse_core_defines.svh"

module bssr_dpath #(
    parameter int DEPTH = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  bssr_pkg::t_dp_cmd                 i_cmd,
    input  logic signed [bssr_pkg::WordW-1:0] i_push_value,
    output bssr_pkg::t_dp_stat                o_stat,
    output logic signed [bssr_pkg::WordW-1:0] o_data_word,
    output logic [bssr_pkg::StatW-1:0]        o_status,
    output logic [bssr_pkg::CntOutW-1:0]      o_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [bssr_pkg::WordW-1:0] r_mem [DEPTH];
    logic [bssr_pkg::WordW-1:0] r_rd_data;
    logic [CW-1:0]              r_count;
    logic [CW-1:0]              n_count;
    logic [CW-1:0]              cnt_m1;
    logic [AW-1:0]              r_lo;
    logic [AW-1:0]              r_hi;
    logic [CW-1:0]              r_i;
    logic [AW-1:0]              r_j;
    logic [AW-1:0]              j_m1;
    logic [bssr_pkg::WordW-1:0] r_key;
    logic [bssr_pkg::WordW-1:0] r_tmp;

    logic                       rd_en;
    logic [AW-1:0]              rd_addr;
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic [bssr_pkg::WordW-1:0] wr_data;
    logic [CW+bssr_pkg::CntOutW-1:0] cnt_ext;

    logic signed [bssr_pkg::WordW-1:0] r_out_data;
    logic [bssr_pkg::StatW-1:0]        r_out_status;
    logic [bssr_pkg::CntOutW-1:0]      r_out_count;

    assign cnt_m1  = r_count - CW'(1);
    assign j_m1    = r_j - AW'(1);
    assign cnt_ext = {{bssr_pkg::CntOutW{1'b0}}, n_count};

    always_comb begin
        n_count = r_count;
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        case (i_cmd.op)
            bssr_pkg::DP_PUSH: begin
                wr_en   = 1'b1;
                wr_addr = r_count[AW-1:0];
                wr_data = i_push_value;
                n_count = r_count + CW'(1);
            end
            bssr_pkg::DP_POP: begin
                rd_en   = 1'b1;
                rd_addr = cnt_m1[AW-1:0];
                n_count = cnt_m1;
            end
            bssr_pkg::DP_PEEK: begin
                rd_en   = 1'b1;
                rd_addr = cnt_m1[AW-1:0];
            end
            bssr_pkg::DP_CLEAR: begin
                n_count = '0;
            end
            bssr_pkg::DP_REV_RD_LO: begin
                rd_en   = 1'b1;
                rd_addr = r_lo;
            end
            bssr_pkg::DP_REV_RD_HI: begin
                rd_en   = 1'b1;
                rd_addr = r_hi;
            end
            bssr_pkg::DP_REV_WR_LO: begin
                wr_en   = 1'b1;
                wr_addr = r_lo;
                wr_data = r_rd_data;
            end
            bssr_pkg::DP_REV_WR_HI: begin
                wr_en   = 1'b1;
                wr_addr = r_hi;
                wr_data = r_tmp;
            end
            bssr_pkg::DP_SORT_RD_KEY: begin
                rd_en   = 1'b1;
                rd_addr = r_i[AW-1:0];
            end
            bssr_pkg::DP_SORT_RD_PREV: begin
                rd_en   = 1'b1;
                rd_addr = j_m1;
            end
            bssr_pkg::DP_SORT_SHIFT: begin
                wr_en   = 1'b1;
                wr_addr = r_j;
                wr_data = r_rd_data;
            end
            bssr_pkg::DP_SORT_PLACE: begin
                wr_en   = 1'b1;
                wr_addr = r_j;
                wr_data = r_key;
            end
            default: ;
        endcase
    end

    // stack storage, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // walk indices for reverse and sort
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            bssr_pkg::DP_REV_INIT: begin
                r_lo <= '0;
                r_hi <= cnt_m1[AW-1:0];
            end
            bssr_pkg::DP_REV_RD_HI: begin
                r_tmp <= r_rd_data;
            end
            bssr_pkg::DP_REV_WR_HI: begin
                r_lo <= r_lo + AW'(1);
                r_hi <= r_hi - AW'(1);
            end
            bssr_pkg::DP_SORT_INIT: begin
                r_i <= CW'(1);
            end
            bssr_pkg::DP_SORT_LOAD_KEY: begin
                r_key <= r_rd_data;
                r_j   <= r_i[AW-1:0];
            end
            bssr_pkg::DP_SORT_SHIFT: begin
                r_j <= j_m1;
            end
            bssr_pkg::DP_SORT_PLACE: begin
                r_i <= r_i + CW'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data   <= i_cmd.out_use_rd ? r_rd_data : '0;
            r_out_status <= i_cmd.out_status;
            r_out_count  <= cnt_ext[bssr_pkg::CntOutW-1:0];
        end
    end

    assign o_stat.empty      = (r_count == '0);
    assign o_stat.full       = (r_count == CW'(DEPTH));
    assign o_stat.lo_lt_hi   = (r_lo < r_hi);
    assign o_stat.i_lt_count = (r_i < r_count);
    assign o_stat.j_nz       = (r_j != '0);
    assign o_stat.key_gt     = ($signed(r_key) > $signed(r_rd_data));

    assign o_data_word = r_out_data;
    assign o_status    = r_out_status;
    assign o_count     = r_out_count;

    `BSSR_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(DEPTH), "count past depth")
    `BSSR_ASSERT_NOW(a_shift_above_bottom, i_clk, i_rst_n, i_cmd.op == bssr_pkg::DP_SORT_SHIFT, r_j != '0, "sort shift at bottom")

endmodule

[rtl/bssr_ctrl.sv]
`timescale 1ns / 1ps
`include "bounded_stack_sort_reverse_core_defines.svh"

module bssr_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [bssr_pkg::ActW-1:0]     i_action,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    input  bssr_pkg::t_dp_stat            i_stat,
    output bssr_pkg::t_dp_cmd             o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_DONE,
        ST_REV_CHK,
        ST_REV_HI,
        ST_REV_WR_LO,
        ST_REV_WR_HI,
        ST_SORT_CHK,
        ST_SORT_KEY,
        ST_SORT_J,
        ST_SORT_CMP
    } t_state;

    t_state            r_state;
    t_state            n_state;
    logic              r_out_valid;
    logic              n_out_valid;
    logic              s_accept;
    bssr_pkg::t_dp_cmd cmd;

    assign o_s_tready = (r_state == ST_IDLE) && (!r_out_valid || i_m_tready);
    assign s_accept   = i_s_tvalid && o_s_tready;

    always_comb begin
        n_state        = r_state;
        cmd.op         = bssr_pkg::DP_NONE;
        cmd.out_load   = 1'b0;
        cmd.out_status = bssr_pkg::STAT_OK;
        cmd.out_use_rd = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    unique case (i_action) inside
                        bssr_pkg::ACT_PUSH: begin
                            cmd.out_load = 1'b1;
                            if (i_stat.full) begin
                                cmd.out_status = bssr_pkg::STAT_OVERFLOW;
                            end else begin
                                cmd.op = bssr_pkg::DP_PUSH;
                            end
                        end
                        bssr_pkg::ACT_POP, bssr_pkg::ACT_PEEK: begin
                            if (i_stat.empty) begin
                                cmd.out_load   = 1'b1;
                                cmd.out_status = bssr_pkg::STAT_EMPTY;
                            end else begin
                                cmd.op  = (i_action == bssr_pkg::ACT_POP) ?
                                          bssr_pkg::DP_POP : bssr_pkg::DP_PEEK;
                                n_state = ST_RD_DONE;
                            end
                        end
                        bssr_pkg::ACT_CLEAR: begin
                            cmd.op       = bssr_pkg::DP_CLEAR;
                            cmd.out_load = 1'b1;
                        end
                        bssr_pkg::ACT_REVERSE: begin
                            if (i_stat.empty) begin
                                cmd.out_load   = 1'b1;
                                cmd.out_status = bssr_pkg::STAT_EMPTY;
                            end else begin
                                cmd.op  = bssr_pkg::DP_REV_INIT;
                                n_state = ST_REV_CHK;
                            end
                        end
                        bssr_pkg::ACT_SORT: begin
                            if (i_stat.empty) begin
                                cmd.out_load   = 1'b1;
                                cmd.out_status = bssr_pkg::STAT_EMPTY;
                            end else begin
                                cmd.op  = bssr_pkg::DP_SORT_INIT;
                                n_state = ST_SORT_CHK;
                            end
                        end
                        default: begin
                            cmd.out_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_RD_DONE: begin
                cmd.out_load   = 1'b1;
                cmd.out_use_rd = 1'b1;
                n_state        = ST_IDLE;
            end
            ST_REV_CHK: begin
                if (i_stat.lo_lt_hi) begin
                    cmd.op  = bssr_pkg::DP_REV_RD_LO;
                    n_state = ST_REV_HI;
                end else begin
                    cmd.out_load = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            ST_REV_HI: begin
                cmd.op  = bssr_pkg::DP_REV_RD_HI;
                n_state = ST_REV_WR_LO;
            end
            ST_REV_WR_LO: begin
                cmd.op  = bssr_pkg::DP_REV_WR_LO;
                n_state = ST_REV_WR_HI;
            end
            ST_REV_WR_HI: begin
                cmd.op  = bssr_pkg::DP_REV_WR_HI;
                n_state = ST_REV_CHK;
            end
            ST_SORT_CHK: begin
                if (i_stat.i_lt_count) begin
                    cmd.op  = bssr_pkg::DP_SORT_RD_KEY;
                    n_state = ST_SORT_KEY;
                end else begin
                    cmd.out_load = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            ST_SORT_KEY: begin
                cmd.op  = bssr_pkg::DP_SORT_LOAD_KEY;
                n_state = ST_SORT_J;
            end
            ST_SORT_J: begin
                if (i_stat.j_nz) begin
                    cmd.op  = bssr_pkg::DP_SORT_RD_PREV;
                    n_state = ST_SORT_CMP;
                end else begin
                    cmd.op  = bssr_pkg::DP_SORT_PLACE;
                    n_state = ST_SORT_CHK;
                end
            end
            ST_SORT_CMP: begin
                if (i_stat.key_gt) begin
                    cmd.op  = bssr_pkg::DP_SORT_SHIFT;
                    n_state = ST_SORT_J;
                end else begin
                    cmd.op  = bssr_pkg::DP_SORT_PLACE;
                    n_state = ST_SORT_CHK;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_cmd      = cmd;

    `BSSR_ASSERT_NOW(a_no_result_overwrite, i_clk, i_rst_n, cmd.out_load, !r_out_valid || i_m_tready, "result overwritten")
    `BSSR_ASSERT_NEXT(a_pop_reads_top, i_clk, i_rst_n, s_accept && i_action == bssr_pkg::ACT_POP && !i_stat.empty, cmd.out_load && cmd.out_use_rd, "pop result missing")

endmodule

[rtl/bounded_stack_sort_reverse_core.sv]
// result: push, clear, unused codes and failed actions register it on acceptance; pop and peek read first
// reverse of n entries: each swap reads the low and high entries, then writes them back crossed
// sort of n entries: insertion sort on signed words, largest at the bottom and smallest at the top
// flow: one transaction at a time; the next is taken when idle and the result is handed over or gone
// reset: i_rst_n synchronous active low, clears count and controller; stored words keep contents
`timescale 1ns / 1ps

module bounded_stack_sort_reverse_core #(
    parameter int DEPTH = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // action[2:0], push_value[34:3], zero pad[39:35]
    input  logic [bssr_pkg::InTdataW-1:0]      i_s_tdata,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // data_word[31:0], status[33:32], count[37:34], zero pad[39:38]
    output logic [bssr_pkg::OutTdataW-1:0]     o_m_tdata
);

    bssr_pkg::t_dp_cmd                  cmd;
    bssr_pkg::t_dp_stat                 stat;
    logic signed [bssr_pkg::WordW-1:0]  data_word;
    logic [bssr_pkg::StatW-1:0]         status;
    logic [bssr_pkg::CntOutW-1:0]       count;

    bssr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_action   (i_s_tdata[bssr_pkg::ActW-1:0]),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    bssr_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_push_value (i_s_tdata[bssr_pkg::ActW +: bssr_pkg::WordW]),
        .o_stat       (stat),
        .o_data_word  (data_word),
        .o_status     (status),
        .o_count      (count)
    );

    assign o_m_tdata = {{(bssr_pkg::OutTdataW - bssr_pkg::WordW - bssr_pkg::StatW
                          - bssr_pkg::CntOutW){1'b0}}, count, status, data_word};

endmodule
